>>> hw/rtl/kmc_pkg.sv
// Shared types and constants for the max-inner-product k-means block.
// No dependencies; used by dot_product_kmeans_clustering.
package kmc_pkg;

    localparam int COORD_BITS = 16;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_RUN    = 2'd1,
        MODE_READ_C = 2'd2,
        MODE_READ_A = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_POINT_COUNT   = 2'd0,
        REG_CLUSTER_COUNT = 2'd1,
        REG_DIMENSION     = 2'd2,
        REG_NONE          = 2'd3
    } t_reg_idx;

    localparam logic [7:0] POINT_COUNT_RST   = 8'd128;
    localparam logic [7:0] CLUSTER_COUNT_RST = 8'd128;
    localparam logic [8:0] DIMENSION_RST     = 9'd256;

endpackage

>>> hw/rtl/kmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hw/rtl/dot_product_kmeans_clustering.sv
// Max-inner-product k-means clustering engine built around five RAMs.
// Depends on kmc_pkg (types, constants) and kmc_ram (storage).
//
//  channel   | signals                                         | handshake
//  ----------+-------------------------------------------------+-----------------------------
//  command   | i_mode i_point_index i_cluster_index i_dim_index | start & !busy
//            | i_coord                                         |
//  result    | o_coord_out o_cluster_out o_rounds_run          | o_strobe, one cycle, no stall
//            | o_converged                                     |
//  config    | psel penable pwrite paddr pwdata prdata pready  | APB write, pready tied high
//
//  Load and read items: accepted back to back, one per cycle; the result strobes
//  the cycle after acceptance, with the registered RAM read data.
//  Run item: busy stays high through centroid seeding, then per round through the
//  dot products (one coordinate pair per cycle through one port of each RAM), the
//  count clear, the sums, and per non-empty cluster the serial restoring divider
//  (one quotient bit per cycle).
//  Reset is synchronous and active low; it clears control state and the status.
//  The receiver cannot stall: each result is taken in the cycle it is shown.
module dot_product_kmeans_clustering #(
    parameter int MAX_POINTS   = 128,
    parameter int MAX_CLUSTERS = 128,
    parameter int MAX_DIM      = 256,
    parameter int MAX_ROUNDS   = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_point_index,
    input  logic [6:0]  i_cluster_index,
    input  logic [7:0]  i_dim_index,
    input  logic signed [15:0] i_coord,
    // result channel
    output logic        o_strobe,
    output logic signed [15:0] o_coord_out,
    output logic [6:0]  o_cluster_out,
    output logic [4:0]  o_rounds_run,
    output logic        o_converged
);

    localparam int CB  = kmc_pkg::COORD_BITS;
    localparam int PW  = $clog2(MAX_POINTS);
    localparam int KW  = $clog2(MAX_CLUSTERS);
    localparam int DW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);       // member count
    localparam int SW  = CB + PW;                       // coordinate sum
    localparam int AW  = 2 * CB + DW;                   // dot accumulator
    localparam int RW  = $clog2(MAX_ROUNDS + 1);
    localparam int SCW = $clog2(SW);
    localparam int PAW = PW + DW;
    localparam int KAW = KW + DW;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_INIT  = 17'h00002,
        ST_INITW = 17'h00004,
        ST_ASGN  = 17'h00008,
        ST_ADRN  = 17'h00010,
        ST_CLRC  = 17'h00020,
        ST_SUMA  = 17'h00040,
        ST_SUMC  = 17'h00080,
        ST_SUMD0 = 17'h00100,
        ST_SUMD  = 17'h00200,
        ST_UCNT  = 17'h00400,
        ST_UCHK  = 17'h00800,
        ST_URD   = 17'h01000,
        ST_UWAIT = 17'h02000,
        ST_UDIV  = 17'h04000,
        ST_UWR   = 17'h08000,
        ST_REND  = 17'h10000
    } t_state;

    t_state r_state, n_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] r_point_count, r_cluster_count;
    logic [8:0] r_dimension;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= kmc_pkg::POINT_COUNT_RST;
            r_cluster_count <= kmc_pkg::CLUSTER_COUNT_RST;
            r_dimension     <= kmc_pkg::DIMENSION_RST;
        end else if (cfg_we) begin
            unique case (kmc_pkg::t_reg_idx'(paddr[3:2]))
                kmc_pkg::REG_POINT_COUNT:   r_point_count   <= pwdata[7:0];
                kmc_pkg::REG_CLUSTER_COUNT: r_cluster_count <= pwdata[7:0];
                kmc_pkg::REG_DIMENSION:     r_dimension     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (kmc_pkg::t_reg_idx'(paddr[3:2]))
            kmc_pkg::REG_POINT_COUNT:   prdata = 32'(r_point_count);
            kmc_pkg::REG_CLUSTER_COUNT: prdata = 32'(r_cluster_count);
            kmc_pkg::REG_DIMENSION:     prdata = 32'(r_dimension);
            default:                    prdata = '0;
        endcase
    end

    // Clamp the counts at run start: zero counts as one, overflow as the max.
    logic [31:0] n32, k32, d32, nm1_32, km1_32, dm1_32;
    always_comb begin
        n32 = (r_point_count == '0) ? 32'd1 :
              ((32'(r_point_count) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(r_point_count));
        k32 = (r_cluster_count == '0) ? 32'd1 :
              ((32'(r_cluster_count) > MAX_CLUSTERS) ? 32'(MAX_CLUSTERS)
                                                      : 32'(r_cluster_count));
        d32 = (r_dimension == '0) ? 32'd1 :
              ((32'(r_dimension) > MAX_DIM) ? 32'(MAX_DIM) : 32'(r_dimension));
        nm1_32 = n32 - 32'd1;
        km1_32 = k32 - 32'd1;
        dm1_32 = d32 - 32'd1;
    end

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    logic        accept;
    logic [31:0] pi32, ci32, di32;
    logic        pi_ok, ci_ok, di_ok;
    logic [PW-1:0] h_pi;
    logic [KW-1:0] h_ci;
    logic [DW-1:0] h_di;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start & ~busy;
    assign pi32   = 32'(i_point_index);
    assign ci32   = 32'(i_cluster_index);
    assign di32   = 32'(i_dim_index);
    assign pi_ok  = pi32 < MAX_POINTS;
    assign ci_ok  = ci32 < MAX_CLUSTERS;
    assign di_ok  = di32 < MAX_DIM;
    assign h_pi   = pi32[PW-1:0];
    assign h_ci   = ci32[KW-1:0];
    assign h_di   = di32[DW-1:0];

    // ------------------------------------------------------------------
    // Engine registers
    // ------------------------------------------------------------------
    logic [PW-1:0] r_nm1, r_i, r_pj;
    logic [KW-1:0] r_km1, r_j, r_c;
    logic [DW-1:0] r_dm1, r_d;
    logic [RW-1:0] r_rnd;
    logic          r_changed;

    // seeding write-back
    logic           r_iv;
    logic [KAW-1:0] r_iaddr;

    // dot-product pipeline
    logic          r_a1v, r_a1first, r_a1lastd, r_a1lastj;
    logic [KW-1:0] r_a1j;
    logic [PW-1:0] r_a1i;
    logic          r_a2v, r_a2first, r_a2lastd, r_a2lastj;
    logic [KW-1:0] r_a2j;
    logic [PW-1:0] r_a2i;
    logic signed [2*CB-1:0] r_a2prod;
    logic signed [AW-1:0]   r_acc, r_best;
    logic [KW-1:0]          r_bi;

    // sum write-back
    logic           r_swv, r_cz;
    logic [KAW-1:0] r_swaddr;

    // divider
    logic [CW-1:0]  r_cnt, r_rem;
    logic [SW-1:0]  r_q;
    logic           r_neg;
    logic [SCW-1:0] r_step;
    logic [CB-1:0]  r_old;

    // status and result
    logic [RW-1:0] r_rounds_run;
    logic          r_conv, r_ostb, r_ook;
    logic [1:0]    r_omode;

    // ------------------------------------------------------------------
    // RAMs
    // ------------------------------------------------------------------
    logic           p_we;
    logic [PAW-1:0] p_waddr, p_raddr;
    logic [CB-1:0]  p_rdata;
    logic           c_we;
    logic [KAW-1:0] c_waddr, c_raddr;
    logic [CB-1:0]  c_wdata, c_rdata;
    logic           s_we;
    logic [KAW-1:0] s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;
    logic           n_we;
    logic [KW-1:0]  n_waddr, n_raddr;
    logic [CW-1:0]  n_wdata, n_rdata;
    logic           a_we;
    logic [PW-1:0]  a_waddr, a_raddr;
    logic [KW-1:0]  a_wdata, a_rdata;

    kmc_ram #(.WIDTH(CB), .DEPTH(1 << PAW)) u_point_ram (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(i_coord),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );
    kmc_ram #(.WIDTH(CB), .DEPTH(1 << KAW)) u_cent_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    kmc_ram #(.WIDTH(SW), .DEPTH(1 << KAW)) u_sum_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(r_swaddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    kmc_ram #(.WIDTH(CW), .DEPTH(1 << KW)) u_count_ram (
        .i_clk(i_clk), .i_we(n_we), .i_waddr(n_waddr), .i_wdata(n_wdata),
        .i_raddr(n_raddr), .o_rdata(n_rdata)
    );
    kmc_ram #(.WIDTH(KW), .DEPTH(1 << PW)) u_assign_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );

    // Point RAM: host loads, engine reads.
    assign p_we    = accept && (i_mode == kmc_pkg::MODE_LOAD) && pi_ok && di_ok;
    assign p_waddr = {h_pi, h_di};
    always_comb begin
        if (r_state == ST_INIT) begin
            p_raddr = {r_pj, r_d};
        end else begin
            p_raddr = {r_i, r_d};
        end
    end

    // Centroid RAM: seeding write-back or the divider result.
    logic [SW-1:0] q_signed;
    logic [CB-1:0] new_coord;
    assign q_signed  = r_neg ? (~r_q + SW'(1)) : r_q;
    assign new_coord = q_signed[CB-1:0];

    assign c_we    = r_iv || (r_state == ST_UWR);
    assign c_waddr = r_iv ? r_iaddr : {r_j, r_d};
    assign c_wdata = r_iv ? p_rdata : new_coord;
    always_comb begin
        if (r_state == ST_IDLE) begin
            c_raddr = {h_ci, h_di};
        end else begin
            c_raddr = {r_j, r_d};
        end
    end

    // Sum RAM: a cluster whose count is still zero this round reads as empty.
    assign s_we    = r_swv;
    assign s_wdata = (r_cz ? '0 : s_rdata) + SW'($signed(p_rdata));
    always_comb begin
        if (r_state == ST_SUMD) begin
            s_raddr = {r_c, r_d};
        end else begin
            s_raddr = {r_j, r_d};
        end
    end

    // Count RAM: cleared each round, then bumped once per point.
    assign n_we    = (r_state == ST_CLRC) || (r_state == ST_SUMD0);
    assign n_waddr = (r_state == ST_CLRC) ? r_j : r_c;
    assign n_wdata = (r_state == ST_CLRC) ? '0 : (n_rdata + CW'(1));
    assign n_raddr = (r_state == ST_SUMC) ? a_rdata : r_j;

    // Dot-product compare stage and assignment write.
    logic signed [AW-1:0] dot;
    logic                 better;
    assign dot    = (r_a2first ? '0 : r_acc) + AW'(r_a2prod);
    assign better = (r_a2j == '0) || (dot > r_best);

    assign a_we    = r_a2v && r_a2lastd && r_a2lastj;
    assign a_waddr = r_a2i;
    assign a_wdata = better ? r_a2j : r_bi;
    assign a_raddr = (r_state == ST_IDLE) ? h_pi : r_i;

    // Divider step.
    logic [CW:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_q[SW-1]};
    assign div_ge = div_t >= (CW+1)'(r_cnt);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic rnd_last;
    logic [RW-1:0] rnd_inc;
    assign rnd_inc  = r_rnd + RW'(1);
    assign rnd_last = !r_changed || (32'(rnd_inc) == MAX_ROUNDS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && i_mode == kmc_pkg::MODE_RUN) n_state = ST_INIT;
            ST_INIT:  if (r_d == r_dm1 && r_j == r_km1) n_state = ST_INITW;
            ST_INITW: n_state = ST_ASGN;
            ST_ASGN:  if (r_d == r_dm1 && r_j == r_km1 && r_i == r_nm1) n_state = ST_ADRN;
            ST_ADRN:  if (!r_a1v && !r_a2v) n_state = ST_CLRC;
            ST_CLRC:  if (r_j == r_km1) n_state = ST_SUMA;
            ST_SUMA:  n_state = ST_SUMC;
            ST_SUMC:  n_state = ST_SUMD0;
            ST_SUMD0: n_state = ST_SUMD;
            ST_SUMD: begin
                if (r_d == r_dm1) n_state = (r_i == r_nm1) ? ST_UCNT : ST_SUMA;
            end
            ST_UCNT:  n_state = ST_UCHK;
            ST_UCHK: begin
                if (n_rdata != '0) n_state = ST_URD;
                else if (r_j == r_km1) n_state = ST_REND;
                else n_state = ST_UCNT;
            end
            ST_URD:   n_state = ST_UWAIT;
            ST_UWAIT: n_state = ST_UDIV;
            ST_UDIV:  if (r_step == '0) n_state = ST_UWR;
            ST_UWR: begin
                if (r_d != r_dm1) n_state = ST_URD;
                else if (r_j == r_km1) n_state = ST_REND;
                else n_state = ST_UCNT;
            end
            ST_REND:  n_state = rnd_last ? ST_IDLE : ST_ASGN;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_iv         <= 1'b0;
            r_a1v        <= 1'b0;
            r_a2v        <= 1'b0;
            r_swv        <= 1'b0;
            r_ostb       <= 1'b0;
            r_rounds_run <= '0;
            r_conv       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iv    <= (r_state == ST_INIT);
            r_a1v   <= (r_state == ST_ASGN);
            r_a2v   <= r_a1v;
            r_swv   <= (r_state == ST_SUMD);
            r_ostb  <= (accept && i_mode != kmc_pkg::MODE_RUN) ||
                       (r_state == ST_REND && rnd_last);
            if (r_state == ST_REND && rnd_last) begin
                r_rounds_run <= rnd_inc;
                r_conv       <= !r_changed;
            end
        end
    end

    // Counters and datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_omode <= i_mode;
            r_ook   <= (i_mode == kmc_pkg::MODE_READ_C) ? (ci_ok && di_ok) : pi_ok;
        end

        r_iaddr   <= {r_j, r_d};
        r_a1first <= (r_d == '0);
        r_a1lastd <= (r_d == r_dm1);
        r_a1lastj <= (r_j == r_km1);
        r_a1j     <= r_j;
        r_a1i     <= r_i;
        r_a2first <= r_a1first;
        r_a2lastd <= r_a1lastd;
        r_a2lastj <= r_a1lastj;
        r_a2j     <= r_a1j;
        r_a2i     <= r_a1i;
        r_a2prod  <= $signed(p_rdata) * $signed(c_rdata);
        r_swaddr  <= {r_c, r_d};

        if (r_a2v) begin
            r_acc <= dot;
            if (r_a2lastd && better) begin
                r_best <= dot;
                r_bi   <= r_a2j;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                r_nm1     <= nm1_32[PW-1:0];
                r_km1     <= km1_32[KW-1:0];
                r_dm1     <= dm1_32[DW-1:0];
                r_i       <= '0;
                r_j       <= '0;
                r_d       <= '0;
                r_pj      <= '0;
                r_rnd     <= '0;
                r_changed <= 1'b0;
            end
            ST_INIT: begin
                // advance coordinate, then centroid; the seed point wraps at n
                if (r_d == r_dm1) begin
                    r_d  <= '0;
                    r_j  <= r_j + KW'(1);
                    r_pj <= (r_pj == r_nm1) ? '0 : r_pj + PW'(1);
                end else begin
                    r_d <= r_d + DW'(1);
                end
            end
            ST_INITW: begin
                r_i <= '0;
                r_j <= '0;
                r_d <= '0;
            end
            ST_ASGN: begin
                if (r_d == r_dm1) begin
                    r_d <= '0;
                    if (r_j == r_km1) begin
                        r_j <= '0;
                        r_i <= r_i + PW'(1);
                    end else begin
                        r_j <= r_j + KW'(1);
                    end
                end else begin
                    r_d <= r_d + DW'(1);
                end
            end
            ST_ADRN: begin
                r_j <= '0;
            end
            ST_CLRC: begin
                r_i <= '0;
                r_j <= r_j + KW'(1);
            end
            ST_SUMA: ;
            ST_SUMC: begin
                r_c <= a_rdata;
            end
            ST_SUMD0: begin
                r_cz <= (n_rdata == '0);
                r_d  <= '0;
            end
            ST_SUMD: begin
                if (r_d == r_dm1) begin
                    r_d <= '0;
                    r_i <= r_i + PW'(1);
                    r_j <= '0;
                end else begin
                    r_d <= r_d + DW'(1);
                end
            end
            ST_UCNT: ;
            ST_UCHK: begin
                r_cnt <= n_rdata;
                r_d   <= '0;
                if (n_rdata == '0) r_j <= r_j + KW'(1);
            end
            ST_URD: ;
            ST_UWAIT: begin
                r_old  <= c_rdata;
                r_neg  <= s_rdata[SW-1];
                r_q    <= s_rdata[SW-1] ? (~s_rdata + SW'(1)) : s_rdata;
                r_rem  <= '0;
                r_step <= SCW'(SW - 1);
            end
            ST_UDIV: begin
                // one quotient bit per cycle, restoring
                r_rem  <= div_ge ? CW'(div_t - (CW+1)'(r_cnt)) : div_t[CW-1:0];
                r_q    <= {r_q[SW-2:0], div_ge};
                r_step <= r_step - SCW'(1);
            end
            ST_UWR: begin
                if (new_coord != r_old) r_changed <= 1'b1;
                if (r_d == r_dm1) begin
                    r_d <= '0;
                    r_j <= r_j + KW'(1);
                end else begin
                    r_d <= r_d + DW'(1);
                end
            end
            ST_REND: begin
                r_rnd     <= rnd_inc;
                r_changed <= 1'b0;
                r_i       <= '0;
                r_j       <= '0;
                r_d       <= '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    logic [31:0] a_rd32, rr32;
    assign a_rd32 = 32'(a_rdata);
    assign rr32   = 32'(r_rounds_run);

    assign o_strobe      = r_ostb;
    assign o_coord_out   = (r_omode == kmc_pkg::MODE_READ_C && r_ook) ? c_rdata : '0;
    assign o_cluster_out = (r_omode == kmc_pkg::MODE_READ_A && r_ook) ? a_rd32[6:0] : '0;
    assign o_rounds_run  = rr32[4:0];
    assign o_converged   = r_conv;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_short_item_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode != kmc_pkg::MODE_RUN) |=> o_strobe)
        else $error("load or read item gave no result");

    a_result_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while a run is in progress");

    a_assign_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_we |-> (r_state == ST_ASGN || r_state == ST_ADRN))
        else $error("assignment written outside the assignment phase");

    a_pipe_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLRC) |-> (!r_a1v && !r_a2v))
        else $error("dot-product pipeline busy after the assignment phase");

endmodule
